[src/variable_record_ring_fifo_macros.svh]
// assertion macros shared by the ring fifo
`ifndef VARIABLE_RECORD_RING_FIFO_MACROS_SVH
`define VARIABLE_RECORD_RING_FIFO_MACROS_SVH

// same-cycle implication
`define VRF_ASSERT_IMPL(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VRF_ASSERT_NEXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/vrf_pkg.sv]
`timescale 1ns / 1ps
package vrf_pkg;

	localparam int OP_W       = 2;
	localparam int LEN_W      = 5;
	localparam int KIND_W     = 8;
	localparam int STATUS_W   = 3;
	localparam int CAP_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] STS_WORD     = 3'd0;
	localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd1;
	localparam logic [STATUS_W-1:0] STS_DROPPED  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_ACCEPTED = 3'd3;
	localparam logic [STATUS_W-1:0] STS_REJECTED = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RECORD = 1'b1;

	localparam logic [CAP_W-1:0] CAP_RESET    = 11'd1024;
	localparam logic [LEN_W-1:0] MAXREC_RESET = 5'd16;

	typedef enum logic [1:0] {
		CMD_PUSH_FIRST,
		CMD_PUSH_NEXT,
		CMD_POP,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [LEN_W-1:0]   words;
		logic [KIND_W-1:0]  rkind;
		logic [LEN_W-1:0]   limit;
	} vrf_ctl_t;

	typedef struct packed {
		logic [CAP_W-1:0] capacity;
		logic [LEN_W-1:0] max_record;
	} vrf_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_HEAD,
		ST_POP_DROP,
		ST_POP_RUN
	} eng_state_t;

endpackage

[src/vrf_channels.sv]
`timescale 1ns / 1ps
interface vrf_req_if
	import vrf_pkg::*;
#(
	parameter int WORD_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic                  first_word;
	logic [LEN_W-1:0]      record_words;
	logic [KIND_W-1:0]     record_kind;
	logic [WORD_BITS-1:0]  data_word;
	logic [LEN_W-1:0]      pop_limit_words;

	modport source (
		output valid, operation, first_word, record_words, record_kind, data_word,
			pop_limit_words,
		input ready
	);
	modport sink (
		input valid, operation, first_word, record_words, record_kind, data_word,
			pop_limit_words,
		output ready
	);
endinterface

interface vrf_rsp_if
	import vrf_pkg::*;
#(
	parameter int WORD_BITS = 32
);
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [WORD_BITS-1:0]  out_word;
	logic [KIND_W-1:0]     out_kind;
	logic [LEN_W-1:0]      out_length;
	logic                  last_of_run;

	modport source (
		output valid, status, out_word, out_kind, out_length, last_of_run,
		input ready
	);
	modport sink (
		input valid, status, out_word, out_kind, out_length, last_of_run,
		output ready
	);
endinterface

[src/vrf_front.sv]
`timescale 1ns / 1ps
module vrf_front
	import vrf_pkg::*;
#(
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	vrf_req_if.sink              req,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output vrf_ctl_t             cmd_ctl,
	output logic [WORD_BITS-1:0] cmd_data
);

	logic                 valid_s1;
	vrf_ctl_t             ctl_s1;
	logic [WORD_BITS-1:0] data_s1;
	vrf_ctl_t             ctl_d;
	logic                 keep;
	logic                 take;

	assign req.ready = !valid_s1 || cmd_ready;
	assign take      = req.valid && req.ready;

	// classify the transfer; unused operation codes are swallowed here
	always_comb begin
		keep       = 1'b1;
		ctl_d.kind  = CMD_CLEAR;
		ctl_d.words = req.record_words;
		ctl_d.rkind = req.record_kind;
		ctl_d.limit = req.pop_limit_words;
		unique case (req.operation)
			OP_PUSH:  ctl_d.kind = req.first_word ? CMD_PUSH_FIRST : CMD_PUSH_NEXT;
			OP_POP:   ctl_d.kind = CMD_POP;
			OP_CLEAR: ctl_d.kind = CMD_CLEAR;
			default:  keep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= keep;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1  <= ctl_d;
			data_s1 <= req.data_word;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd_ctl   = ctl_s1;
	assign cmd_data  = data_s1;

endmodule

[src/vrf_cmd_queue.sv]
`timescale 1ns / 1ps
module vrf_cmd_queue
	import vrf_pkg::*;
#(
	parameter int W = 52
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	logic [W-1:0]     ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != (PTR_W+1)'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

[src/vrf_engine.sv]
`timescale 1ns / 1ps
module vrf_engine
	import vrf_pkg::*;
#(
	parameter int BUFFER_WORDS = 1024,
	parameter int MAX_RECORD   = 16,
	parameter int WORD_BITS    = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vrf_cfg_t             cfg,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  vrf_ctl_t             cmd_ctl,
	input  logic [WORD_BITS-1:0] cmd_data,
	vrf_rsp_if.source            rsp
);

	localparam int AW = $clog2(BUFFER_WORDS);
	localparam int PW = $clog2(BUFFER_WORDS + 1);
	localparam int SW = PW + 1;
	localparam int CW = (PW > CAP_W) ? PW : CAP_W;
	localparam int EW = WORD_BITS + KIND_W + LEN_W;

	eng_state_t state_q, state_d;

	logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, end_q, end_d, fill_q, fill_d;
	logic in_prog_q, in_prog_d, acc_q, acc_d;
	logic [LEN_W-1:0] rem_q, rem_d, plen_q, plen_d;
	logic [KIND_W-1:0] pkind_q, pkind_d;
	logic [LEN_W-1:0] len_q, len_d, idx_q, idx_d, limit_q, limit_d;
	logic [KIND_W-1:0] kind_q, kind_d;

	logic [EW-1:0]  store_q [BUFFER_WORDS];
	logic [EW-1:0]  rd_data_q;
	logic           mem_we, mem_re;
	logic [AW-1:0]  mem_waddr, mem_raddr;
	logic [EW-1:0]  mem_wdata;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [WORD_BITS-1:0]  out_word_q;
	logic [KIND_W-1:0]     out_kind_q;
	logic [LEN_W-1:0]      out_len_q;
	logic                  out_last_q;
	logic                  out_free, out_load;
	logic [STATUS_W-1:0]   o_status;
	logic [WORD_BITS-1:0]  o_word;
	logic [KIND_W-1:0]     o_kind;
	logic [LEN_W-1:0]      o_len;
	logic                  o_last;

	logic [CW-1:0]    cap_w, buf_w;
	logic [PW-1:0]    cap_eff;
	logic [LEN_W-1:0] c_len;
	logic [SW-1:0]    len_x, cap_x, fill_x, wp_sum;
	logic             len_ok, ring_empty, over_fill, wrap_case, rp_room, collide;
	logic             admit_ok, wrap_take;
	logic [PW-1:0]    wp_e, rp_e, end_e, wp_adm;

	logic [PW-1:0]    cm_wp, cm_end, cm_fin, cm_end_new;
	logic [LEN_W-1:0] cm_len;
	logic [PW-1:0]    wr_next_ptr, pop_rp, rd_next_ptr, rp_retire, fill_retire;

	logic [WORD_BITS-1:0] rd_word;
	logic [KIND_W-1:0]    rd_kind;
	logic [LEN_W-1:0]     rd_len, rd_len0, clip1, clip2, idx_nx;
	logic                 run_last;

	// effective ring size
	assign cap_w   = CW'(cfg.capacity);
	assign buf_w   = CW'(BUFFER_WORDS);
	assign cap_eff = (cap_w > buf_w) ? PW'(buf_w) : PW'(cap_w);

	// placement check for a new record
	assign c_len      = cmd_ctl.words;
	assign len_ok     = (c_len != '0) && (c_len <= cfg.max_record) && (int'(c_len) <= MAX_RECORD);
	assign ring_empty = fill_q == '0;
	assign wp_e       = ring_empty ? '0 : wp_q;
	assign rp_e       = ring_empty ? '0 : rp_q;
	assign end_e      = ring_empty ? '0 : end_q;
	assign len_x      = SW'(c_len);
	assign cap_x      = {1'b0, cap_eff};
	assign fill_x     = {1'b0, fill_q};
	assign over_fill  = (fill_x + len_x) > cap_x;
	assign wp_sum     = {1'b0, wp_e} + len_x;
	assign wrap_case  = (wp_e == end_e) && (wp_sum > cap_x);
	assign rp_room    = {1'b0, rp_e} >= len_x;
	assign collide    = (wp_e < end_e) && (wp_sum > {1'b0, rp_e});
	assign admit_ok   = len_ok && !over_fill && (wrap_case ? rp_room : !collide);
	assign wrap_take  = len_ok && !over_fill && wrap_case && rp_room;
	assign wp_adm     = wrap_take ? '0 : wp_e;

	// commit of a finished record
	always_comb begin
		if (cmd_ctl.kind == CMD_PUSH_FIRST) begin
			cm_wp  = wp_adm;
			cm_end = end_e;
			cm_len = c_len;
		end else begin
			cm_wp  = wp_q;
			cm_end = end_q;
			cm_len = plen_q;
		end
	end
	assign cm_fin     = cm_wp + PW'(cm_len);
	assign cm_end_new = (cm_fin > cm_end) ? cm_fin : cm_end;

	assign wr_next_ptr = wp_q + PW'(LEN_W'(plen_q - rem_q));
	assign pop_rp      = (rp_q == end_q) ? '0 : rp_q;

	// head entry of a pop
	assign rd_word  = rd_data_q[EW-1 -: WORD_BITS];
	assign rd_kind  = rd_data_q[LEN_W +: KIND_W];
	assign rd_len   = rd_data_q[LEN_W-1:0];
	assign rd_len0  = (rd_len == '0) ? LEN_W'(1) : rd_len;
	assign clip1    = (PW'(rd_len0) > fill_q) ? LEN_W'(fill_q) : rd_len0;
	assign clip2    = (int'(clip1) > MAX_RECORD) ? LEN_W'(MAX_RECORD) : clip1;

	assign idx_nx      = idx_q + LEN_W'(1);
	assign run_last    = idx_nx == len_q;
	assign rd_next_ptr = rp_q + PW'(idx_nx);
	assign rp_retire   = rp_q + PW'(len_q);
	assign fill_retire = fill_q - PW'(len_q);

	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		end_d     = end_q;
		fill_d    = fill_q;
		in_prog_d = in_prog_q;
		acc_d     = acc_q;
		rem_d     = rem_q;
		plen_d    = plen_q;
		pkind_d   = pkind_q;
		len_d     = len_q;
		idx_d     = idx_q;
		limit_d   = limit_q;
		kind_d    = kind_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = wp_adm[AW-1:0];
		mem_raddr = pop_rp[AW-1:0];
		mem_wdata = {cmd_data, cmd_ctl.rkind, c_len};
		cmd_ready = 1'b0;
		out_load  = 1'b0;
		o_status  = STS_WORD;
		o_word    = '0;
		o_kind    = '0;
		o_len     = '0;
		o_last    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd_ctl.kind)
						CMD_PUSH_FIRST: begin
							if ((c_len > LEN_W'(1)) || out_free) begin
								cmd_ready = 1'b1;
								if (len_ok) begin
									wp_d  = wp_adm;
									rp_d  = rp_e;
									end_d = end_e;
								end
								if (c_len == '0) begin
									in_prog_d = 1'b0;
									acc_d     = 1'b0;
									out_load  = 1'b1;
									o_status  = STS_REJECTED;
									o_last    = 1'b1;
								end else begin
									plen_d    = c_len;
									rem_d     = c_len - LEN_W'(1);
									pkind_d   = cmd_ctl.rkind;
									acc_d     = admit_ok;
									in_prog_d = 1'b1;
									mem_we    = admit_ok;
									if (c_len == LEN_W'(1)) begin
										in_prog_d = 1'b0;
										acc_d     = 1'b0;
										out_load  = 1'b1;
										o_last    = 1'b1;
										if (admit_ok) begin
											wp_d     = cm_fin;
											end_d    = cm_end_new;
											fill_d   = fill_q + PW'(cm_len);
											o_status = STS_ACCEPTED;
											o_len    = c_len;
										end else begin
											o_status = STS_REJECTED;
										end
									end
								end
							end
						end
						CMD_PUSH_NEXT: begin
							if (!in_prog_q) begin
								cmd_ready = 1'b1;
							end else if ((rem_q != LEN_W'(1)) || out_free) begin
								cmd_ready = 1'b1;
								rem_d     = rem_q - LEN_W'(1);
								mem_we    = acc_q;
								mem_waddr = wr_next_ptr[AW-1:0];
								mem_wdata = {cmd_data, pkind_q, plen_q};
								if (rem_q == LEN_W'(1)) begin
									in_prog_d = 1'b0;
									acc_d     = 1'b0;
									out_load  = 1'b1;
									o_last    = 1'b1;
									if (acc_q) begin
										wp_d     = cm_fin;
										end_d    = cm_end_new;
										fill_d   = fill_q + PW'(cm_len);
										o_status = STS_ACCEPTED;
										o_len    = plen_q;
									end else begin
										o_status = STS_REJECTED;
									end
								end
							end
						end
						CMD_POP: begin
							if (ring_empty) begin
								if (out_free) begin
									cmd_ready = 1'b1;
									out_load  = 1'b1;
									o_status  = STS_EMPTY;
									o_last    = 1'b1;
								end
							end else begin
								cmd_ready = 1'b1;
								rp_d      = pop_rp;
								if (rp_q == end_q) begin
									end_d = wp_q;
								end
								mem_re  = 1'b1;
								limit_d = cmd_ctl.limit;
								state_d = ST_POP_HEAD;
							end
						end
						CMD_CLEAR: begin
							cmd_ready = 1'b1;
							wp_d      = '0;
							rp_d      = '0;
							end_d     = '0;
							fill_d    = '0;
							in_prog_d = 1'b0;
							acc_d     = 1'b0;
							rem_d     = '0;
							plen_d    = '0;
						end
					endcase
				end
			end
			ST_POP_HEAD: begin
				len_d   = clip2;
				kind_d  = rd_kind;
				idx_d   = '0;
				state_d = (clip2 > limit_q) ? ST_POP_DROP : ST_POP_RUN;
			end
			ST_POP_DROP: begin
				if (out_free) begin
					out_load = 1'b1;
					o_status = STS_DROPPED;
					o_kind   = kind_q;
					o_len    = len_q;
					o_last   = 1'b1;
					rp_d     = rp_retire;
					fill_d   = fill_retire;
					state_d  = ST_IDLE;
				end
			end
			ST_POP_RUN: begin
				if (out_free) begin
					out_load = 1'b1;
					o_status = STS_WORD;
					o_word   = rd_word;
					o_kind   = kind_q;
					o_len    = len_q;
					o_last   = run_last;
					if (run_last) begin
						rp_d    = rp_retire;
						fill_d  = fill_retire;
						state_d = ST_IDLE;
					end else begin
						idx_d     = idx_nx;
						mem_re    = 1'b1;
						mem_raddr = rd_next_ptr[AW-1:0];
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			rp_q      <= '0;
			end_q     <= '0;
			fill_q    <= '0;
			in_prog_q <= 1'b0;
			acc_q     <= 1'b0;
			rem_q     <= '0;
			plen_q    <= '0;
			pkind_q   <= '0;
			len_q     <= '0;
			idx_q     <= '0;
			limit_q   <= '0;
			kind_q    <= '0;
		end else begin
			state_q   <= state_d;
			wp_q      <= wp_d;
			rp_q      <= rp_d;
			end_q     <= end_d;
			fill_q    <= fill_d;
			in_prog_q <= in_prog_d;
			acc_q     <= acc_d;
			rem_q     <= rem_d;
			plen_q    <= plen_d;
			pkind_q   <= pkind_d;
			len_q     <= len_d;
			idx_q     <= idx_d;
			limit_q   <= limit_d;
			kind_q    <= kind_d;
		end
	end

	// record store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= store_q[mem_raddr];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= o_status;
			out_word_q   <= o_word;
			out_kind_q   <= o_kind;
			out_len_q    <= o_len;
			out_last_q   <= o_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.out_word    = out_word_q;
	assign rsp.out_kind    = out_kind_q;
	assign rsp.out_length  = out_len_q;
	assign rsp.last_of_run = out_last_q;

endmodule

[src/variable_record_ring_fifo.sv]
`timescale 1ns / 1ps
// push word: one per cycle unless back-pressured; the last word of a record gives a report
// pop of n words: the head entry is first read through the registered read port of the record store
// words of a pop leave at one per cycle while rsp is ready, a dropped or empty pop gives one result
// reset: pointers, fill level and push state cleared, registers to defaults,
// store contents undefined with no clearing pass
`include "variable_record_ring_fifo_macros.svh"

module variable_record_ring_fifo
	import vrf_pkg::*;
#(
	parameter int BUFFER_WORDS = 1024,
	parameter int MAX_RECORD   = 16,
	parameter int WORD_BITS    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	vrf_req_if.sink               req,
	vrf_rsp_if.source             rsp
);

	localparam int CTL_W = $bits(vrf_ctl_t);
	localparam int QW    = CTL_W + WORD_BITS;

	vrf_cfg_t             cfg_q;
	logic                 front_valid, front_ready;
	vrf_ctl_t             front_ctl;
	logic [WORD_BITS-1:0] front_data;
	logic                 eng_valid, eng_ready;
	logic [QW-1:0]        q_out;
	vrf_ctl_t             eng_ctl;
	logic [WORD_BITS-1:0] eng_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity   <= CAP_RESET;
			cfg_q.max_record <= MAXREC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAPACITY:   cfg_q.capacity   <= cfg_data[CAP_W-1:0];
				REG_MAX_RECORD: cfg_q.max_record <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	vrf_front #(
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd_ctl   (front_ctl),
		.cmd_data  (front_data)
	);

	vrf_cmd_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   ({front_ctl, front_data}),
		.out_valid (eng_valid),
		.out_ready (eng_ready),
		.out_data  (q_out)
	);

	assign eng_ctl  = vrf_ctl_t'(q_out[QW-1 -: CTL_W]);
	assign eng_data = q_out[WORD_BITS-1:0];

	vrf_engine #(
		.BUFFER_WORDS (BUFFER_WORDS),
		.MAX_RECORD   (MAX_RECORD),
		.WORD_BITS    (WORD_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (eng_valid),
		.cmd_ready (eng_ready),
		.cmd_ctl   (eng_ctl),
		.cmd_data  (eng_data),
		.rsp       (rsp)
	);

	`VRF_ASSERT_IMPL(a_report_ends_run, clk, arst_n, rsp.valid && (rsp.status != STS_WORD), rsp.last_of_run, "report not marked as end of run")
	`VRF_ASSERT_IMPL(a_no_data_reports, clk, arst_n, rsp.valid && ((rsp.status == STS_EMPTY) || (rsp.status == STS_REJECTED)), (rsp.out_length == '0) && (rsp.out_word == '0) && (rsp.out_kind == '0), "empty or rejected report carries data")
	`VRF_ASSERT_IMPL(a_word_has_length, clk, arst_n, rsp.valid && (rsp.status == STS_WORD), rsp.out_length != '0, "popped word with zero record length")
	`VRF_ASSERT_NEXT(a_pop_reaches_front, clk, arst_n, req.valid && req.ready && (req.operation == OP_POP), front_valid, "pop transfer lost at the front stage")

endmodule
